[rtl/chr_pkg.sv]
// Shared types, constants and helper functions for the cookie header recognizer.
// Depends on nothing; imported by the top level, chr_class and chr_parse.
package chr_pkg;

   // Saturation widths for the byte counter and the pair counter.
   localparam int LENGTH_BITS = 16;
   localparam int COUNT_BITS  = 8;

   // Characters the grammar looks for.
   localparam logic [7:0] CH_TAB      = 8'd9;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_BANG     = 8'd33;
   localparam logic [7:0] CH_QUOTE    = 8'd34;
   localparam logic [7:0] CH_COMMA    = 8'd44;
   localparam logic [7:0] CH_COLON    = 8'd58;
   localparam logic [7:0] CH_SEMI     = 8'd59;
   localparam logic [7:0] CH_EQUAL    = 8'd61;
   localparam logic [7:0] CH_LBRACKET = 8'd91;
   localparam logic [7:0] CH_BSLASH   = 8'd92;
   localparam logic [7:0] CH_RBRACKET = 8'd93;
   localparam logic [7:0] CH_TILDE    = 8'd126;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   // Character classes of one header byte.
   typedef struct packed {
      logic       ws;      // space or tab
      logic       space;   // space only
      logic       tchar;   // token character
      logic       octet;   // cookie octet
      logic       colon;
      logic       semi;
      logic       equal;
      logic       quote;
      logic [7:0] lower;   // byte with the case bit forced on
   } chr_class_type;

   // One result item.
   typedef struct packed {
      logic                  accepted;
      logic [COUNT_BITS-1:0] pairs;
      logic [LENGTH_BITS-1:0] length;
   } chr_result_type;

   // Lower-case letters of the leading word "cookie".
   function automatic logic [7:0] word_letter(input logic [2:0] idx);
      logic [7:0] letter;
      case (idx)
         3'd0:    letter = 8'h63; // c
         3'd1:    letter = 8'h6f; // o
         3'd2:    letter = 8'h6f; // o
         3'd3:    letter = 8'h6b; // k
         3'd4:    letter = 8'h69; // i
         3'd5:    letter = 8'h65; // e
         default: letter = 8'h00;
      endcase
      return letter;
   endfunction

endpackage

[rtl/chr_if.sv]
// Valid/ready channel interfaces for header bytes and recognition results.
// Depends on nothing; used by the top level of the cookie header recognizer.
interface chr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       is_final;

   modport source (output valid, output header_byte, output is_final, input ready);
   modport sink (input valid, input header_byte, input is_final, output ready);
endinterface

interface chr_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [7:0]  pair_count;
   logic [15:0] header_length;

   modport source (output valid, output accepted, output pair_count,
                   output header_length, input ready);
   modport sink (input valid, input accepted, input pair_count,
                 input header_length, output ready);
endinterface

[rtl/cookie_header_recognizer_top.sv]
// A final byte is first held in the input register; once the parser takes it, the parser
// loads the result register, which then offers the result.
// Throughput: one byte per cycle, set by the single-pass grammar state machine; a final
// byte waits only while a previous result is still held. Reset (synchronous, active
// high) empties both registers and returns the parser to the start of the leading word
// with zeroed counters. Depends on chr_pkg, chr_if, chr_class and chr_parse.
module cookie_header_recognizer_top (
   input logic        clock,
   input logic        reset,
   chr_req_if.sink    req_port,
   chr_rsp_if.source  rsp_port
);
   import chr_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_final_ff;
   logic           req_fire;
   logic           take;
   chr_class_type  cls;
   chr_result_type result;

   // Input register accepts a new byte whenever it is empty or the parser drains the current one.
   assign req_port.ready = !in_valid_ff || take;
   assign req_fire       = req_port.valid && req_port.ready;
   assign in_valid_in    = req_fire || (in_valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_port.header_byte;
         in_final_ff <= req_port.is_final;
      end
   end

   // Character classes of the held byte.
   chr_class u_class (
      .header_byte (in_byte_ff),
      .cls         (cls)
   );

   // Grammar check and result register.
   chr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_final  (in_final_ff),
      .cls       (cls),
      .take      (take),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_port.valid),
      .result    (result)
   );

   // Result transfer payload.
   assign rsp_port.accepted      = result.accepted;
   assign rsp_port.pair_count    = 8'(result.pairs);
   assign rsp_port.header_length = 16'(result.length);

endmodule

[rtl/chr_class.sv]
// Character classifier: sorts one header byte into the classes the grammar uses.
// Depends on chr_pkg.
module chr_class (
   input  logic [7:0]            header_byte,
   output chr_pkg::chr_class_type cls
);
   import chr_pkg::*;

   logic is_alpha;
   logic is_digit;
   logic is_special;

   // Letters, digits and the token punctuation set.
   assign is_alpha = ((header_byte >= 8'h61) && (header_byte <= 8'h7a)) ||
                     ((header_byte >= 8'h41) && (header_byte <= 8'h5a));
   assign is_digit = (header_byte >= 8'h30) && (header_byte <= 8'h39);

   always_comb begin
      case (header_byte)
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
         8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: is_special = 1'b1;
         default: is_special = 1'b0;
      endcase
   end

   // Class flags handed to the parser.
   always_comb begin
      cls.space = (header_byte == CH_SPACE);
      cls.ws    = (header_byte == CH_SPACE) || (header_byte == CH_TAB);
      cls.tchar = is_alpha || is_digit || is_special;
      cls.octet = (header_byte == CH_BANG) ||
                  ((header_byte > CH_QUOTE) && (header_byte < CH_COMMA)) ||
                  ((header_byte > CH_COMMA) && (header_byte <= CH_COLON)) ||
                  ((header_byte > CH_SEMI) && (header_byte <= CH_LBRACKET)) ||
                  ((header_byte >= CH_RBRACKET) && (header_byte <= CH_TILDE));
      cls.colon = (header_byte == CH_COLON);
      cls.semi  = (header_byte == CH_SEMI);
      cls.equal = (header_byte == CH_EQUAL);
      cls.quote = (header_byte == CH_QUOTE);
      cls.lower = header_byte | CASE_BIT;
   end

endmodule

[rtl/chr_parse.sv]
// Grammar state machine, byte and pair counters, and the result register.
// Depends on chr_pkg; fed by chr_class through the top-level input register.
module chr_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    in_final,
   input  chr_pkg::chr_class_type  cls,
   output logic                    take,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output chr_pkg::chr_result_type result
);
   import chr_pkg::*;

   // Phase codes; values below PH_COLON index the letters of "cookie".
   localparam logic [3:0] PH_WORD       = 4'd0;
   localparam logic [3:0] PH_COLON      = 4'd6;
   localparam logic [3:0] PH_LEAD_WS    = 4'd7;
   localparam logic [3:0] PH_NAME       = 4'd8;
   localparam logic [3:0] PH_VAL_START  = 4'd9;
   localparam logic [3:0] PH_VAL_PLAIN  = 4'd10;
   localparam logic [3:0] PH_VAL_QUOTED = 4'd11;
   localparam logic [3:0] PH_VAL_CLOSED = 4'd12;
   localparam logic [3:0] PH_SEP        = 4'd13;
   localparam logic [3:0] PH_PAIR_START = 4'd14;
   localparam logic [3:0] PH_TRAIL_WS   = 4'd15;

   localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   logic [3:0]             phase_ff, phase_in, phase_adv;
   logic                   rej_ff, rej_in, rej_adv;
   logic [COUNT_BITS-1:0]  pairs_ff, pairs_in, pairs_next;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in, pos_next;
   logic                   rsp_valid_ff, rsp_valid_in;
   chr_result_type         result_ff, result_in;
   logic                   adv_inc;
   logic                   fin_inc;
   logic                   fin_ok;
   logic                   pair_inc;
   logic                   fire_final;

   // A byte moves on unless it is the final one and the result slot is still full.
   assign take       = in_valid && (!in_final || !rsp_valid_ff || rsp_ready);
   assign fire_final = take && in_final;

   // Next phase for one byte; an error is sticky until the header ends.
   always_comb begin
      phase_adv = phase_ff;
      rej_adv   = rej_ff;
      adv_inc   = 1'b0;
      if (!rej_ff) begin
         if (phase_ff < PH_COLON) begin
            if (cls.lower == word_letter(phase_ff[2:0])) begin
               phase_adv = phase_ff + 4'd1;
            end else begin
               rej_adv = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_COLON: begin
                  if (cls.colon) phase_adv = PH_LEAD_WS;
                  else rej_adv = 1'b1;
               end
               PH_LEAD_WS: begin
                  if (cls.tchar) phase_adv = PH_NAME;
                  else if (!cls.ws) rej_adv = 1'b1;
               end
               PH_NAME: begin
                  if (cls.equal) phase_adv = PH_VAL_START;
                  else if (!cls.tchar) rej_adv = 1'b1;
               end
               PH_VAL_START, PH_VAL_PLAIN: begin
                  if (cls.quote && (phase_ff == PH_VAL_START)) begin
                     phase_adv = PH_VAL_QUOTED;
                  end else if (cls.octet) begin
                     phase_adv = PH_VAL_PLAIN;
                  end else if (cls.semi) begin
                     adv_inc   = 1'b1;
                     phase_adv = PH_SEP;
                  end else if (cls.ws) begin
                     adv_inc   = 1'b1;
                     phase_adv = PH_TRAIL_WS;
                  end else begin
                     rej_adv = 1'b1;
                  end
               end
               PH_VAL_QUOTED: begin
                  if (cls.quote) begin
                     adv_inc   = 1'b1;
                     phase_adv = PH_VAL_CLOSED;
                  end else if (!cls.octet) begin
                     rej_adv = 1'b1;
                  end
               end
               PH_VAL_CLOSED: begin
                  if (cls.semi) phase_adv = PH_SEP;
                  else if (cls.ws) phase_adv = PH_TRAIL_WS;
                  else rej_adv = 1'b1;
               end
               PH_SEP: begin
                  if (cls.space) phase_adv = PH_PAIR_START;
                  else rej_adv = 1'b1;
               end
               PH_PAIR_START: begin
                  if (cls.tchar) phase_adv = PH_NAME;
                  else rej_adv = 1'b1;
               end
               PH_TRAIL_WS: begin
                  if (!cls.ws) rej_adv = 1'b1;
               end
               default: begin
                  rej_adv = 1'b1;
               end
            endcase
         end
      end
   end

   // End-of-header verdict; an unquoted or empty value still open counts as a pair.
   assign fin_inc  = !rej_adv && ((phase_adv == PH_VAL_START) || (phase_adv == PH_VAL_PLAIN));
   assign fin_ok   = fin_inc || (!rej_adv &&
                     ((phase_adv == PH_VAL_CLOSED) || (phase_adv == PH_TRAIL_WS)));
   assign pair_inc = adv_inc || (in_final && fin_inc);

   // Saturating counters.
   assign pairs_next = (pair_inc && (pairs_ff != CNT_MAX)) ? pairs_ff + 1'b1 : pairs_ff;
   assign pos_next   = (pos_ff != LEN_MAX) ? pos_ff + 1'b1 : pos_ff;

   // State update: a final byte loads the result and returns the parser to reset.
   always_comb begin
      phase_in     = phase_ff;
      rej_in       = rej_ff;
      pairs_in     = pairs_ff;
      pos_in       = pos_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         if (in_final) begin
            phase_in           = PH_WORD;
            rej_in             = 1'b0;
            pairs_in           = '0;
            pos_in             = '0;
            result_in.accepted = fin_ok;
            result_in.pairs    = pairs_next;
            result_in.length   = pos_next;
            rsp_valid_in       = 1'b1;
         end else begin
            phase_in = phase_adv;
            rej_in   = rej_adv;
            pairs_in = pairs_next;
            pos_in   = pos_next;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WORD;
         rej_ff       <= 1'b0;
         pairs_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rej_ff       <= rej_in;
         pairs_ff     <= pairs_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   // The parser is back at its reset state after every final byte.
   a_reset_after_final: assert property (@(posedge clock) disable iff (reset)
      fire_final |=> (phase_ff == PH_WORD) && !rej_ff && (pairs_ff == '0) && (pos_ff == '0))
      else $error("parser state not cleared after final byte");

   // A result only appears because a final byte was taken.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire_final))
      else $error("result raised without a final byte");

   // An accepted header always carries at least one pair.
   a_accept_pairs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.accepted) |-> (result_ff.pairs != '0))
      else $error("accepted header with no pairs");

   // An error stays set until the header ends.
   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      (rej_ff && !fire_final) |=> rej_ff)
      else $error("reject flag cleared inside a header");

endmodule
